// File: src/fprgba_pkg.sv
// Shared types and constants for the float pixel to RGBA8 unpacker.
package fprgba_pkg;

	localparam int unsigned NUM_LANES = 4;
	localparam logic [7:0] UNORM_MAX = 8'd255;

	typedef enum logic [3:0] {
		FMT_RED       = 4'd0,
		FMT_GREEN     = 4'd1,
		FMT_BLUE      = 4'd2,
		FMT_ALPHA     = 4'd3,
		FMT_LUM       = 4'd4,
		FMT_LUM_ALPHA = 4'd5,
		FMT_RGB       = 4'd6,
		FMT_RGBA      = 4'd7,
		FMT_BGR       = 4'd8,
		FMT_BGRA      = 4'd9
	} fprgba_fmt_t;

	localparam fprgba_fmt_t FMT_RESET = FMT_RGBA;

	// Converted components, one byte per lane, in source order.
	typedef struct packed {
		logic [7:0] c3;
		logic [7:0] c2;
		logic [7:0] c1;
		logic [7:0] c0;
	} fprgba_lanes_t;

endpackage

// File: src/fprgba_if.sv
// Stream interfaces for source pixels and RGBA8 texels.
interface fprgba_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] comp0;
	logic [31:0] comp1;
	logic [31:0] comp2;
	logic [31:0] comp3;
	logic        end_of_image;

	modport source (output valid, comp0, comp1, comp2, comp3, end_of_image, input ready);
	modport sink (input valid, comp0, comp1, comp2, comp3, end_of_image, output ready);
endinterface

interface fprgba_texel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       last_texel;

	modport source (output valid, red, green, blue, alpha, last_texel, input ready);
	modport sink (input valid, red, green, blue, alpha, last_texel, output ready);
endinterface

// File: src/fprgba_lane.sv
// One conversion lane: IEEE single times 255, rounded, truncated and saturated to 8 bits.
module fprgba_lane (
	input  logic        clk,
	input  logic        en_s1,
	input  logic        en_s2,
	input  logic [31:0] comp,
	output logic [7:0]  unorm
);
	import fprgba_pkg::*;

	logic       sgn;
	logic [7:0] expo;
	logic [22:0] frac;
	logic [23:0] mant;
	logic [31:0] prod;
	logic       zero_c;
	logic       sat_c;
	logic [2:0] sh_c;

	logic [31:0] p_s1;
	logic [2:0]  sh_s1;
	logic        zero_s1;
	logic        sat_s1;

	logic        n;
	logic [31:0] q;
	logic        rnd;
	logic [24:0] k;
	logic [3:0]  tsh;
	logic [8:0]  t;
	logic [7:0]  val_c;
	logic [7:0]  val_s2;

	assign sgn  = comp[31];
	assign expo = comp[30:23];
	assign frac = comp[22:0];
	assign mant = {1'b1, frac};
	// m * 255 as m * 256 - m
	assign prod = {mant, 8'd0} - {8'd0, mant};

	always_comb begin
		zero_c = 1'b0;
		sat_c  = 1'b0;
		sh_c   = 3'd0;
		if (expo == 8'hFF && frac != 23'd0) begin
			zero_c = 1'b1;
		end else if (sgn) begin
			zero_c = 1'b1;
		end else if (expo >= 8'd127) begin
			sat_c = 1'b1;
		end else if (expo < 8'd119) begin
			// below 2^-8 the product stays under one
			zero_c = 1'b1;
		end else begin
			sh_c = 3'(8'd126 - expo);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p_s1    <= prod;
			sh_s1   <= sh_c;
			zero_s1 <= zero_c;
			sat_s1  <= sat_c;
		end
	end

	// Normalize, round to 24 bits nearest-even, then keep the integer part.
	assign n   = ~p_s1[31];
	assign q   = n ? {p_s1[30:0], 1'b0} : p_s1;
	assign rnd = q[7] & ((|q[6:0]) | q[8]);
	assign k   = {1'b0, q[31:8]} + {24'd0, rnd};
	assign tsh = {1'b0, sh_s1} + {3'd0, n};
	assign t   = k[24:16] >> tsh;

	always_comb begin
		if (zero_s1) begin
			val_c = 8'd0;
		end else if (sat_s1 || t >= {1'b0, UNORM_MAX}) begin
			val_c = UNORM_MAX;
		end else begin
			val_c = t[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			val_s2 <= val_c;
		end
	end

	assign unorm = val_s2;
endmodule

// File: src/fprgba_merge.sv
// Swizzle of the lane results into an RGBA8 texel, with the output register.
module fprgba_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fprgba_pkg::fprgba_fmt_t   fmt,
	input  fprgba_pkg::fprgba_lanes_t lanes,
	input  logic                      last_in,
	input  logic                      valid_in,
	output logic                      ready_out,
	fprgba_texel_if.source            texel
);
	import fprgba_pkg::*;

	logic [7:0] r_c, g_c, b_c, a_c;
	logic       valid_q;

	always_comb begin
		r_c = 8'd0;
		g_c = 8'd0;
		b_c = 8'd0;
		a_c = 8'd0;
		unique case (fmt)
			FMT_RED: begin
				r_c = lanes.c0; a_c = UNORM_MAX;
			end
			FMT_GREEN: begin
				g_c = lanes.c0; a_c = UNORM_MAX;
			end
			FMT_BLUE: begin
				b_c = lanes.c0; a_c = UNORM_MAX;
			end
			FMT_ALPHA: begin
				a_c = lanes.c0;
			end
			FMT_LUM: begin
				r_c = lanes.c0; g_c = lanes.c0; b_c = lanes.c0; a_c = UNORM_MAX;
			end
			FMT_LUM_ALPHA: begin
				r_c = lanes.c0; g_c = lanes.c0; b_c = lanes.c0; a_c = lanes.c1;
			end
			FMT_RGB: begin
				r_c = lanes.c0; g_c = lanes.c1; b_c = lanes.c2; a_c = UNORM_MAX;
			end
			FMT_RGBA: begin
				r_c = lanes.c0; g_c = lanes.c1; b_c = lanes.c2; a_c = lanes.c3;
			end
			FMT_BGR: begin
				r_c = lanes.c2; g_c = lanes.c1; b_c = lanes.c0; a_c = UNORM_MAX;
			end
			FMT_BGRA: begin
				r_c = lanes.c2; g_c = lanes.c1; b_c = lanes.c0; a_c = lanes.c3;
			end
			default: begin
				// unused codes give a black, transparent texel
				r_c = 8'd0;
			end
		endcase
	end

	assign ready_out = ~valid_q | texel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_out) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_in) begin
			texel.red        <= r_c;
			texel.green      <= g_c;
			texel.blue       <= b_c;
			texel.alpha      <= a_c;
			texel.last_texel <= last_in;
		end
	end

	assign texel.valid = valid_q;
endmodule

// File: src/float_pixel_to_rgba8_unpack_core.sv
// Top level of the float pixel to RGBA8 unpacker.
// One pixel of four IEEE single components is accepted per cycle and leaves as an
// RGBA8 texel: two lane stages (multiply by 255, then round and saturate) run in
// four parallel lanes, and the swizzle stage feeds the output register. Each stage
// stalls only when the one after it is full, so the block keeps one beat per cycle
// whenever the texel side takes one. source_format resets to RGBA; the user
// must write it via cfg_wen/cfg_wdata only while idle, and the block does not enforce it.
module float_pixel_to_rgba8_unpack_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [3:0]   cfg_wdata,
	fprgba_pix_if.sink   pix,
	fprgba_texel_if.source texel
);
	import fprgba_pkg::*;

	fprgba_fmt_t   fmt_q;
	fprgba_lanes_t lanes;
	logic          v_s1, v_s2;
	logic          eoi_s1, eoi_s2;
	logic          en_s1, en_s2;
	logic          merge_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RESET;
		end else if (cfg_wen) begin
			fmt_q <= fprgba_fmt_t'(cfg_wdata);
		end
	end

	assign en_s2     = ~v_s2 | merge_ready;
	assign en_s1     = ~v_s1 | en_s2;
	assign pix.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= pix.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			eoi_s1 <= pix.end_of_image;
		end
		if (en_s2) begin
			eoi_s2 <= eoi_s1;
		end
	end

	fprgba_lane u_lane0 (.clk(clk), .en_s1(en_s1), .en_s2(en_s2), .comp(pix.comp0),
		.unorm(lanes.c0));
	fprgba_lane u_lane1 (.clk(clk), .en_s1(en_s1), .en_s2(en_s2), .comp(pix.comp1),
		.unorm(lanes.c1));
	fprgba_lane u_lane2 (.clk(clk), .en_s1(en_s1), .en_s2(en_s2), .comp(pix.comp2),
		.unorm(lanes.c2));
	fprgba_lane u_lane3 (.clk(clk), .en_s1(en_s1), .en_s2(en_s2), .comp(pix.comp3),
		.unorm(lanes.c3));

	fprgba_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fmt       (fmt_q),
		.lanes     (lanes),
		.last_in   (eoi_s2),
		.valid_in  (v_s2),
		.ready_out (merge_ready),
		.texel     (texel)
	);

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 && !v_s2 && !texel.valid) |-> pix.ready)
		else $error("empty pipeline refuses a beat");

	a_lum_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(texel.valid && fmt_q == FMT_LUM) |->
		(texel.red == texel.green && texel.green == texel.blue && texel.alpha == UNORM_MAX))
		else $error("luminance texel is not gray and opaque");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> v_s1)
		else $error("accepted beat lost in first stage");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !merge_ready) |=> v_s2)
		else $error("stalled beat dropped in second stage");
endmodule
